>>> rtl/heap_sort_engine_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heap sort engine
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HEAP_SORT_ENGINE_UNIT_ASSERT_SVH
`define HEAP_SORT_ENGINE_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define HSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define HSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// Widths, record and control types, and the key compare for the sort engine.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int KEY_W     = 32;
  localparam int PAY_W     = 16;
  localparam int REC_W     = KEY_W + PAY_W;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int KID_W     = IDX_W + 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [KID_W-1:0] kid_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [PAY_W-1:0] pay_t;

  typedef struct packed {
    key_t key;
    pay_t payload;
  } rec_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    rec_t wdata;
    logic re;
    idx_t raddr_a;
    idx_t raddr_b;
  } mem_req_t;

  typedef struct packed {
    key_t cur;
    key_t left;
    key_t right;
    logic right_ok;
    logic sgn;
  } cmp_req_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_TOP_RD,
    ST_TOP_LD,
    ST_SIFT,
    ST_PLACE,
    ST_EXT_RD,
    ST_EXT_WR,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PICK_NODE,
    PICK_LEFT,
    PICK_RIGHT
  } pick_t;

  // a < b; unsigned, or signed when sgn is set, done by flipping the sign bits
  function automatic logic key_less(key_t a, key_t b, logic sgn);
    key_t flip;
    flip = {sgn, {(KEY_W-1){1'b0}}};
    return (a ^ flip) < (b ^ flip);
  endfunction

endpackage

>>> rtl/hse_in_if.sv
// ----------------------------------------------------------------------------
// hse_in_if
// Record input channel: valid/ready with key, payload and set marker.
// ----------------------------------------------------------------------------
interface hse_in_if import hse_pkg::*; ();
  logic valid;
  logic ready;
  key_t key;
  pay_t payload;
  logic last;

  modport source (output valid, output key, output payload, output last, input ready);
  modport sink   (input valid, input key, input payload, input last, output ready);
endinterface

>>> rtl/hse_out_if.sv
// ----------------------------------------------------------------------------
// hse_out_if
// Sorted result channel: valid/ready with key, payload, run end and drop flag.
// ----------------------------------------------------------------------------
interface hse_out_if import hse_pkg::*; ();
  logic valid;
  logic ready;
  key_t key_res;
  pay_t payload_res;
  logic last_res;
  logic dropped;

  modport source (output valid, output key_res, output payload_res, output last_res,
                  output dropped, input ready);
  modport sink   (input valid, input key_res, input payload_res, input last_res,
                  input dropped, output ready);
endinterface

>>> rtl/heap_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// heap_sort_engine_unit
// Heapsort engine: collects records, sorts them ascending by key, emits them.
// ----------------------------------------------------------------------------
// Usage:
//   rec_in takes one record (key, payload, last) per beat, one beat a cycle
//   while in the load state, into a 64-entry record RAM. The beat with last
//   set closes the set; records past 64 are discarded and every result of
//   that run carries dropped. The block then sorts in place and rec_out emits
//   the run in ascending key order, last_res set on its final beat, one beat
//   a cycle while the sink takes them; rec_in stays not ready until the run's
//   final beat is issued. cfg_we/cfg_wdata set signed (1) or unsigned (0)
//   key compare.
// Sort steps: an extract reads root and end (ST_EXT_RD) and swaps them
//   (ST_EXT_WR); a sift call reads its top record (ST_TOP_RD, ST_TOP_LD); each
//   sift level (ST_SIFT) reads both children, compares and writes back; a
//   record that sinks to a leaf is placed in ST_PLACE.
// Reset: clears the set count, overflow flag and pending result; the record
//   RAM needs no clearing, only written entries are read.
// Stall: a stalled sink holds the result beat; the next set may load, but its
//   sort waits until that beat is taken.
// ----------------------------------------------------------------------------
module heap_sort_engine_unit import hse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  hse_in_if.sink    rec_in,
  hse_out_if.source rec_out
);

  logic     key_signed;
  mem_req_t mem_req;
  rec_t     rdata_a;
  rec_t     rdata_b;
  cmp_req_t cmp_req;
  pick_t    pick;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_signed <= 1'b0;
    end else if (cfg_we) begin
      key_signed <= cfg_wdata;
    end
  end

  hse_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .we      (mem_req.we),
    .waddr   (mem_req.waddr),
    .wdata   (mem_req.wdata),
    .re      (mem_req.re),
    .raddr_a (mem_req.raddr_a),
    .raddr_b (mem_req.raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  hse_pick u_pick (
    .req  (cmp_req),
    .pick (pick)
  );

  hse_core u_core (
    .clk         (clk),
    .rst         (rst),
    .key_signed  (key_signed),
    .rec_in      (rec_in),
    .rec_out     (rec_out),
    .mem_req     (mem_req),
    .mem_rdata_a (rdata_a),
    .mem_rdata_b (rdata_b),
    .cmp_req     (cmp_req),
    .pick        (pick)
  );

endmodule

>>> rtl/hse_ram.sv
// ----------------------------------------------------------------------------
// hse_ram
// Generic RAM: one write port, two read ports, registered read with enable.
// ----------------------------------------------------------------------------
module hse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> rtl/hse_pick.sv
// ----------------------------------------------------------------------------
// hse_pick
// Sift-down decision: keep the node or move the larger child up.
// ----------------------------------------------------------------------------
module hse_pick import hse_pkg::*; (
  input  cmp_req_t req,
  output pick_t    pick
);

  logic left_wins;
  logic right_wins;
  key_t best_key;

  always_comb begin
    // left tested first, only a strictly larger child replaces the parent
    left_wins  = key_less(req.cur, req.left, req.sgn);
    best_key   = left_wins ? req.left : req.cur;
    right_wins = req.right_ok && key_less(best_key, req.right, req.sgn);
    if (right_wins) begin
      pick = PICK_RIGHT;
    end else if (left_wins) begin
      pick = PICK_LEFT;
    end else begin
      pick = PICK_NODE;
    end
  end

endmodule

>>> rtl/hse_core.sv
// ----------------------------------------------------------------------------
// hse_core
// Load, heapsort and emit sequencer around the record RAM.
// ----------------------------------------------------------------------------
`include "heap_sort_engine_unit_assert.svh"

module hse_core import hse_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         key_signed,
  hse_in_if.sink       rec_in,
  hse_out_if.source    rec_out,
  output mem_req_t     mem_req,
  input  rec_t         mem_rdata_a,
  input  rec_t         mem_rdata_b,
  output cmp_req_t     cmp_req,
  input  pick_t        pick
);

  state_t state, state_next;
  cnt_t   count, count_next;
  logic   ovf, ovf_next;
  logic   building, building_next;
  logic   out_valid, out_valid_next;
  idx_t   n_m1, n_m1_next;
  idx_t   bottom, bottom_next;
  idx_t   top_i, top_next;
  idx_t   node, node_next;
  idx_t   hi, hi_next;
  idx_t   emit_idx, emit_next;
  rec_t   cur, cur_next;
  logic   last_q, last_next;
  logic   drop_q, drop_next;

  logic   in_beat;
  logic   store_full;
  logic   sink_end;
  kid_t   kid, kid_r, bottom_ext, top_kid, pick_ext, next_kid;
  idx_t   pick_idx;
  rec_t   pick_rec;

  assign in_beat      = rec_in.valid && rec_in.ready;
  assign rec_in.ready = (state == ST_LOAD);
  assign store_full   = (count == CNT_W'(MAX_ITEMS));

  assign kid        = {1'b0, node, 1'b1};
  assign kid_r      = kid + 1'b1;
  assign bottom_ext = {2'b00, bottom};
  assign top_kid    = {1'b0, top_i, 1'b1};
  assign pick_ext   = (pick == PICK_RIGHT) ? kid_r : kid;
  assign pick_idx   = pick_ext[IDX_W-1:0];
  assign next_kid   = {1'b0, pick_idx, 1'b1};
  assign pick_rec   = (pick == PICK_RIGHT) ? mem_rdata_b : mem_rdata_a;

  assign cmp_req.cur      = cur.key;
  assign cmp_req.left     = mem_rdata_a.key;
  assign cmp_req.right    = mem_rdata_b.key;
  assign cmp_req.right_ok = (kid_r <= bottom_ext);
  assign cmp_req.sgn      = key_signed;

  // result beat comes straight from the RAM read register
  assign rec_out.valid       = out_valid;
  assign rec_out.key_res     = mem_rdata_a.key;
  assign rec_out.payload_res = mem_rdata_a.payload;
  assign rec_out.last_res    = last_q;
  assign rec_out.dropped     = drop_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      building  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ovf       <= ovf_next;
      building  <= building_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    n_m1     <= n_m1_next;
    bottom   <= bottom_next;
    top_i    <= top_next;
    node     <= node_next;
    hi       <= hi_next;
    emit_idx <= emit_next;
    cur      <= cur_next;
    last_q   <= last_next;
    drop_q   <= drop_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    ovf_next       = ovf;
    building_next  = building;
    out_valid_next = out_valid && !rec_out.ready;
    n_m1_next      = n_m1;
    bottom_next    = bottom;
    top_next       = top_i;
    node_next      = node;
    hi_next        = hi;
    emit_next      = emit_idx;
    cur_next       = cur;
    last_next      = last_q;
    drop_next      = drop_q;
    sink_end       = 1'b0;
    mem_req        = '0;

    case (state)
      ST_LOAD: begin
        if (in_beat) begin
          if (store_full) begin
            ovf_next = 1'b1;
          end else begin
            mem_req.we            = 1'b1;
            mem_req.waddr         = count[IDX_W-1:0];
            mem_req.wdata.key     = rec_in.key;
            mem_req.wdata.payload = rec_in.payload;
            count_next            = count + 1'b1;
          end
          if (rec_in.last) begin
            n_m1_next  = store_full ? IDX_W'(MAX_ITEMS - 1) : count[IDX_W-1:0];
            state_next = ST_START;
          end
        end
      end

      ST_START: begin
        // the previous run's final beat still sits in the read register
        if (!out_valid) begin
          if (n_m1 == '0) begin
            emit_next  = '0;
            state_next = ST_EMIT;
          end else begin
            building_next = 1'b1;
            bottom_next   = n_m1;
            top_next      = (n_m1 - 1'b1) >> 1;
            state_next    = ST_TOP_RD;
          end
        end
      end

      ST_TOP_RD: begin
        mem_req.re      = 1'b1;
        mem_req.raddr_a = top_i;
        state_next      = ST_TOP_LD;
      end

      ST_TOP_LD: begin
        cur_next  = mem_rdata_a;
        node_next = top_i;
        if (top_kid <= bottom_ext) begin
          mem_req.re      = 1'b1;
          mem_req.raddr_a = top_kid[IDX_W-1:0];
          mem_req.raddr_b = IDX_W'(top_kid + 1'b1);
          state_next      = ST_SIFT;
        end else begin
          sink_end = 1'b1;
        end
      end

      ST_SIFT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = node;
        if (pick == PICK_NODE) begin
          mem_req.wdata = cur;
          sink_end      = 1'b1;
        end else begin
          mem_req.wdata = pick_rec;
          node_next     = pick_idx;
          if (next_kid <= bottom_ext) begin
            mem_req.re      = 1'b1;
            mem_req.raddr_a = next_kid[IDX_W-1:0];
            mem_req.raddr_b = IDX_W'(next_kid + 1'b1);
          end else begin
            state_next = ST_PLACE;
          end
        end
      end

      ST_PLACE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = node;
        mem_req.wdata = cur;
        sink_end      = 1'b1;
      end

      ST_EXT_RD: begin
        mem_req.re      = 1'b1;
        mem_req.raddr_a = '0;
        mem_req.raddr_b = hi;
        state_next      = ST_EXT_WR;
      end

      ST_EXT_WR: begin
        // old root goes to the end, the end record sinks from the root
        mem_req.we    = 1'b1;
        mem_req.waddr = hi;
        mem_req.wdata = mem_rdata_a;
        cur_next      = mem_rdata_b;
        node_next     = '0;
        hi_next       = hi - 1'b1;
        bottom_next   = hi - 1'b1;
        if (hi > IDX_W'(1)) begin
          mem_req.re      = 1'b1;
          mem_req.raddr_a = IDX_W'(1);
          mem_req.raddr_b = IDX_W'(2);
          state_next      = ST_SIFT;
        end else begin
          state_next = ST_PLACE;
        end
      end

      ST_EMIT: begin
        if (!out_valid || rec_out.ready) begin
          mem_req.re      = 1'b1;
          mem_req.raddr_a = emit_idx;
          out_valid_next  = 1'b1;
          last_next       = (emit_idx == n_m1);
          drop_next       = ovf;
          if (emit_idx == n_m1) begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = ST_LOAD;
          end else begin
            emit_next = emit_idx + 1'b1;
          end
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase

    if (sink_end) begin
      if (building) begin
        if (top_i == '0) begin
          building_next = 1'b0;
          hi_next       = n_m1;
          state_next    = ST_EXT_RD;
        end else begin
          top_next   = top_i - 1'b1;
          state_next = ST_TOP_RD;
        end
      end else if (hi == '0) begin
        emit_next  = '0;
        state_next = ST_EMIT;
      end else begin
        state_next = ST_EXT_RD;
      end
    end
  end

  `HSE_ASSERT_SAME(a_ovf_only_full, ovf, store_full, "overflow flagged below capacity")
  `HSE_ASSERT_SAME(a_sift_has_kid, state == ST_SIFT, kid <= bottom_ext,
                   "sift step on a node without children")
  `HSE_ASSERT_SAME(a_emit_slot_free, (state == ST_EMIT) && mem_req.re,
                   !out_valid || rec_out.ready, "result overwritten before taken")
  `HSE_ASSERT_SAME(a_sort_no_result, (state == ST_TOP_RD) || (state == ST_EXT_RD),
                   !out_valid, "sort reads while a result is pending")
  `HSE_ASSERT_NEXT(a_set_nonempty, in_beat && rec_in.last, count != '0,
                   "closed set holds no record")

endmodule

>>> test/heap_sort_engine_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_sort_engine_unit_test
// Feeds record sets through the sort engine under random source gaps and sink
// stalls and checks every sorted beat against a heapsort predictor run on
// each accepted set. Covers unsigned and signed keys, ties and store overflow.
// ----------------------------------------------------------------------------
module heap_sort_engine_unit_test;
  import hse_pkg::*;

  typedef struct {
    key_t key;
    pay_t payload;
    logic last;
  } raw_rec_t;

  typedef struct {
    key_t key;
    pay_t payload;
    logic last;
    logic dropped;
  } sorted_rec_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  hse_in_if  in_ch ();
  hse_out_if out_ch ();

  heap_sort_engine_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .rec_in   (in_ch),
    .rec_out  (out_ch)
  );

  always #2 clk = ~clk;

  // predictor state
  key_t        set_key [MAX_ITEMS];
  pay_t        set_pay [MAX_ITEMS];
  int unsigned set_fill;
  bit          set_lost;
  bit          cmp_signed;

  raw_rec_t    rec_pending[$];
  sorted_rec_t sorted_due[$];
  raw_rec_t    nxt_rec;
  sorted_rec_t got_rec;
  sorted_rec_t exp_rec;

  int unsigned beats_queued;
  int unsigned beats_in;
  int unsigned mismatches;
  int unsigned src_gap;
  int unsigned sink_gap;
  int unsigned sink_wait;
  int unsigned hold_left;
  bit          src_idle;
  bit          sink_idle;
  logic        hold_kick;

  function automatic bit key_below(key_t a, key_t b);
    if (cmp_signed) begin
      return $signed(a) < $signed(b);
    end
    return a < b;
  endfunction

  function automatic void swap_rec(int unsigned a, int unsigned b);
    key_t k;
    pay_t p;
    k = set_key[a];
    p = set_pay[a];
    set_key[a] = set_key[b];
    set_pay[a] = set_pay[b];
    set_key[b] = k;
    set_pay[b] = p;
  endfunction

  // only a strictly smaller parent moves; left child is tried first
  function automatic void sift_down(int unsigned top, int unsigned bottom);
    int unsigned node;
    int unsigned kid;
    int unsigned pick;
    bit          done;
    node = top;
    done = 1'b0;
    while (!done && node * 2 + 1 <= bottom) begin
      kid  = node * 2 + 1;
      pick = node;
      if (key_below(set_key[pick], set_key[kid])) pick = kid;
      if (kid + 1 <= bottom && key_below(set_key[pick], set_key[kid + 1])) pick = kid + 1;
      if (pick == node) begin
        done = 1'b1;
      end else begin
        swap_rec(node, pick);
        node = pick;
      end
    end
  endfunction

  function automatic void heap_order(int unsigned n);
    int unsigned i;
    if (n < 2) return;
    for (i = n / 2; i > 0; i--) sift_down(i - 1, n - 1);
    for (i = n - 1; i > 0; i--) begin
      swap_rec(0, i);
      sift_down(0, i - 1);
    end
  endfunction

  // one accepted record; a set end queues the whole sorted run
  function automatic void load_record(key_t k, pay_t p, logic is_last);
    sorted_rec_t r;
    if (set_fill < MAX_ITEMS) begin
      set_key[set_fill] = k;
      set_pay[set_fill] = p;
      set_fill++;
    end else begin
      set_lost = 1'b1;
    end
    if (is_last) begin
      heap_order(set_fill);
      for (int unsigned i = 0; i < set_fill; i++) begin
        r.key     = set_key[i];
        r.payload = set_pay[i];
        r.last    = (i + 1 == set_fill);
        r.dropped = set_lost;
        sorted_due.push_back(r);
      end
      set_fill = 0;
      set_lost = 1'b0;
    end
  endfunction

  function automatic int unsigned pick_wait(bit on);
    return on ? $urandom_range(0, 15) : 0;
  endfunction

  function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      mismatches++;
    end
  endfunction

  // source side
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      src_gap     <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        load_record(in_ch.key, in_ch.payload, in_ch.last);
        beats_in = beats_in + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap != 0) begin
          src_gap     <= src_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (rec_pending.size() != 0) begin
          nxt_rec = rec_pending.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.key     <= nxt_rec.key;
          in_ch.payload <= nxt_rec.payload;
          in_ch.last    <= nxt_rec.last;
          src_gap       <= pick_wait(src_idle);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long sink hold-off, kicked from the stimulus
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // sink side and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_gap     <= 0;
    end else begin
      sink_wait = sink_gap;
      if (out_ch.valid && out_ch.ready) begin
        got_rec.key     = out_ch.key_res;
        got_rec.payload = out_ch.payload_res;
        got_rec.last    = out_ch.last_res;
        got_rec.dropped = out_ch.dropped;
        if (sorted_due.size() == 0) begin
          $display("%0t: unexpected beat, actual key %h payload %h last %b dropped %b",
                   $time, got_rec.key, got_rec.payload, got_rec.last, got_rec.dropped);
          mismatches++;
        end else begin
          exp_rec = sorted_due.pop_front();
          check_field("key_res", exp_rec.key, got_rec.key);
          check_field("payload_res", 32'(exp_rec.payload), 32'(got_rec.payload));
          check_field("last_res", 32'(exp_rec.last), 32'(got_rec.last));
          check_field("dropped", 32'(exp_rec.dropped), 32'(got_rec.dropped));
        end
        sink_wait = pick_wait(sink_idle);
      end
      if (hold_left != 0 || sink_wait != 0) begin
        out_ch.ready <= 1'b0;
        sink_gap     <= (sink_wait != 0) ? sink_wait - 1 : 0;
      end else begin
        out_ch.ready <= 1'b1;
        sink_gap     <= 0;
      end
    end
  end

  task automatic queue_rec(key_t k, pay_t p, logic is_last);
    raw_rec_t r;
    r.key     = k;
    r.payload = p;
    r.last    = is_last;
    rec_pending.push_back(r);
    beats_queued++;
  endtask

  function automatic key_t rand_key();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return 32'h7FFF_FFFE + $urandom_range(0, 3);
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic pay_t rand_pay();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return pay_t'($urandom);
    endcase
  endfunction

  task automatic queue_set(int unsigned n);
    for (int unsigned i = 0; i < n; i++) queue_rec(rand_key(), rand_pay(), i + 1 == n);
  endtask

  // mostly small sets, a few large, now and then one past capacity
  task automatic queue_rand_sets(int unsigned target);
    int unsigned stop;
    int unsigned r;
    stop = beats_queued + target;
    while (beats_queued < stop) begin
      r = $urandom_range(0, 19);
      if (r < 12) queue_set($urandom_range(1, 8));
      else if (r < 17) queue_set($urandom_range(9, 40));
      else if (r < 19) queue_set($urandom_range(41, MAX_ITEMS));
      else queue_set($urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8));
    end
  endtask

  task automatic drain();
    while (beats_in != beats_queued || sorted_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_key_mode(bit sgn);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= sgn;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cmp_signed = sgn;
  endtask

  task automatic queue_extremes();
    queue_rec(32'h7FFF_FFFF, 16'h0001, 1'b0);
    queue_rec(32'h8000_0000, 16'h0002, 1'b0);
    queue_rec(32'h0000_0000, 16'h0003, 1'b0);
    queue_rec(32'hFFFF_FFFF, 16'h0004, 1'b0);
    queue_rec(32'h0000_0001, 16'h0005, 1'b0);
    queue_rec(32'h8000_0001, 16'hFFFF, 1'b1);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.key     = '0;
    in_ch.payload = '0;
    in_ch.last    = 1'b0;
    out_ch.ready  = 1'b0;
    hold_kick     = 1'b0;
    set_fill      = 0;
    set_lost      = 1'b0;
    cmp_signed    = 1'b0;
    beats_queued  = 0;
    beats_in      = 0;
    mismatches    = 0;
    src_idle      = 1'b1;
    sink_idle     = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed, unsigned: single record, two extremes, ties, mixed extremes
    set_key_mode(1'b0);
    queue_rec(32'h0000_0000, 16'h0000, 1'b1);
    queue_rec(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    queue_rec(32'h0000_0000, 16'h0000, 1'b1);
    for (int i = 1; i <= 4; i++) queue_rec(32'h5, pay_t'(i), i == 4);
    queue_extremes();
    drain();

    // directed, signed: extremes and ties across the sign boundary, then random sets
    set_key_mode(1'b1);
    queue_extremes();
    queue_rec(32'hFFFF_FFFF, 16'h00A0, 1'b0);
    queue_rec(32'hFFFF_FFFF, 16'h00A1, 1'b0);
    queue_rec(32'h0000_0001, 16'h00A2, 1'b1);
    queue_rand_sets(140);
    drain();

    // no idling on either side, plus a set that spills past the store
    set_key_mode(1'b0);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    queue_rand_sets(40);
    queue_set(MAX_ITEMS + 2);
    drain();

    // sink held off while the source keeps offering beats
    set_key_mode(1'b1);
    sink_idle = 1'b1;
    @(posedge clk);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    queue_rand_sets(80);
    drain();

    set_key_mode(1'b0);
    src_idle = 1'b1;
    queue_rand_sets(110);
    drain();
    repeat (100) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/hse_pkg.sv
rtl/hse_in_if.sv
rtl/hse_out_if.sv
rtl/hse_ram.sv
rtl/hse_pick.sv
rtl/hse_core.sv
rtl/heap_sort_engine_unit.sv
test/heap_sort_engine_unit_test.sv
